/* hw/rtl/dos_pkg.sv */
package dos_pkg;

    localparam int unsigned VOLT_W  = 14;
    localparam int unsigned DIST_W  = 23;
    localparam int unsigned ERR_W   = 24;
    localparam int unsigned PID_W   = 16;
    localparam int unsigned OUT_W   = 16;
    localparam int unsigned CFG_W   = 23;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned STEP_W  = 3;
    localparam int unsigned DIV_BITS = 14;
    localparam int unsigned CNT_W   = 4;

    // register map
    typedef enum logic [IDX_W-1:0] {
        REG_DRIVE_CAP_MAX    = 3'd0,
        REG_HEADING_LIMIT    = 3'd1,
        REG_SLOW_ZONE        = 3'd2,
        REG_SLOW_END_VOLTAGE = 3'd3,
        REG_SLEW_ACCEL       = 3'd4,
        REG_SLEW_DECEL       = 3'd5,
        REG_SETTLE_BAND      = 3'd6,
        REG_STILL_THRESHOLD  = 3'd7
    } t_reg_idx;

    // datapath operation of one microcode step
    typedef enum logic [2:0] {
        OP_MUL,
        OP_DIV,
        OP_TAPER,
        OP_BASE,
        OP_SLEW,
        OP_MIX
    } t_op;

    // jump condition of one microcode step
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NOT_ZONE,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } t_cond;

    typedef enum logic [STEP_W-1:0] {
        STEP_MUL   = 3'd0,
        STEP_DIV   = 3'd1,
        STEP_TAPER = 3'd2,
        STEP_BASE  = 3'd3,
        STEP_SLEW  = 3'd4,
        STEP_MIX   = 3'd5
    } t_step;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    // control store
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            STEP_MUL:   w = '{op: OP_MUL,   cond: COND_NOT_ZONE, target: STEP_BASE};
            STEP_DIV:   w = '{op: OP_DIV,   cond: COND_DIV_BUSY, target: STEP_DIV};
            STEP_TAPER: w = '{op: OP_TAPER, cond: COND_ALWAYS,   target: STEP_SLEW};
            STEP_BASE:  w = '{op: OP_BASE,  cond: COND_NEXT,     target: STEP_SLEW};
            STEP_SLEW:  w = '{op: OP_SLEW,  cond: COND_NEXT,     target: STEP_MIX};
            STEP_MIX:   w = '{op: OP_MIX,   cond: COND_OUT_BUSY, target: STEP_MIX};
            default:    w = '{op: OP_MIX,   cond: COND_OUT_BUSY, target: STEP_MIX};
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/drive_output_shaper_top.sv */
// drive output shaper: one item per control tick
// input channel (i_in_valid / o_in_ready) carries the new_move flag, the raw
// drive and heading pid outputs and the signed distance error
// output channel (o_out_valid / i_out_ready) returns one item per input item:
// left and right side voltages and the finished flag
// config channel (i_cfg_valid / o_cfg_ready) writes one of eight registers
// by index; it is always ready and is meant to be used while the block idles
// a microcoded sequencer walks a six-step program per item; the slow-zone
// taper uses a restoring divider that yields one quotient bit per cycle
// an item inside the slow zone passes multiply, 14 divide steps, taper, slew
// and mix; outside it, multiply, base, slew and mix
// the input side is ready again right after the mix step, so the next item
// can start while a result still waits
// when the receiver stalls, the result sits in the output register and the
// next item runs up to its mix step, where it waits for the register to free
// reset loads the register defaults, clears slew and settle state and marks
// the next tick as the first one (no error-change reference yet)
module drive_output_shaper_top #(
    parameter int unsigned DONE_TICKS = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dos_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [dos_pkg::CFG_W-1:0]         i_cfg_data,
    // input items
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_new_move,
    input  logic signed [dos_pkg::PID_W-1:0]  i_drive_pid_output,
    input  logic signed [dos_pkg::PID_W-1:0]  i_heading_pid_output,
    input  logic signed [dos_pkg::ERR_W-1:0]  i_drive_error,
    // result items
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [dos_pkg::OUT_W-1:0]  o_left_voltage,
    output logic signed [dos_pkg::OUT_W-1:0]  o_right_voltage,
    output logic                              o_finished
);
    import dos_pkg::*;

    localparam logic [7:0] FinishCount = 8'(DONE_TICKS);

    // configuration registers
    logic [VOLT_W-1:0] r_cap_max, r_head_lim, r_end, r_accel, r_decel;
    logic [DIST_W-1:0] r_zone, r_band, r_thresh;

    // item under work
    logic signed [PID_W-1:0] r_drv, r_hdg;
    logic signed [ERR_W-1:0] r_err;

    // tick-to-tick state
    logic signed [PID_W-1:0] r_slewed;
    logic signed [ERR_W-1:0] r_prev_err;
    logic                    r_first;
    logic [7:0]              r_count;

    // sequencer
    logic                    r_busy;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [CNT_W-1:0]        r_cnt;
    t_uword                  uw;
    logic                    jump;

    // datapath registers
    logic [DIST_W-1:0]       r_rem;
    logic [DIV_BITS-1:0]     r_quo;
    logic                    r_neg;
    logic [VOLT_W-1:0]       r_cap;
    logic signed [PID_W-1:0] r_head_v;

    // output register
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_left, r_right;
    logic                    r_fin;

    logic in_acc, out_busy, seq_done;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_busy;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_busy    = r_out_valid && !i_out_ready;

    // ---------------- datapath combinational terms ----------------

    // |error|, can reach 2^23 so it keeps the full 24 bits unsigned
    logic [ERR_W-1:0] err_mag;
    logic             in_zone;
    assign err_mag = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
    assign in_zone = (r_zone != '0) && (err_mag < {1'b0, r_zone});

    // taper span and product; the product stays below 2^37
    logic signed [VOLT_W:0]          span;
    logic [VOLT_W-1:0]               span_mag;
    logic [VOLT_W+DIST_W-1:0]        prod;
    assign span     = $signed({1'b0, r_cap_max}) - $signed({1'b0, r_end});
    assign span_mag = span[VOLT_W] ? VOLT_W'(-span) : VOLT_W'(span);
    assign prod     = span_mag * err_mag[DIST_W-1:0];

    // one restoring divide step; remainder stays below slow_zone
    logic [DIST_W:0]   div_shift;
    logic [DIST_W+1:0] div_trial;
    logic              div_ge;
    assign div_shift = {r_rem, r_quo[DIV_BITS-1]};
    assign div_trial = {1'b0, div_shift} - {2'b0, r_zone};
    assign div_ge    = !div_trial[DIST_W+1];

    // tapered cap, raised to end then lowered to base
    logic signed [VOLT_W+2:0] taper_raw;
    logic signed [VOLT_W+2:0] taper_low;
    logic signed [VOLT_W+2:0] end_s, base_s;
    logic [VOLT_W-1:0]        taper_cap;
    assign end_s     = $signed({3'b0, r_end});
    assign base_s    = $signed({3'b0, r_cap_max});
    assign taper_raw = r_neg ? end_s - $signed({3'b0, r_quo})
                             : end_s + $signed({3'b0, r_quo});
    assign taper_low = (taper_raw < end_s) ? end_s : taper_raw;
    assign taper_cap = (taper_low > base_s) ? r_cap_max : taper_low[VOLT_W-1:0];

    // drive clamp and slew
    logic signed [PID_W:0]   cap_s, drv_s, target, slew_s;
    logic [PID_W:0]          tgt_mag, slw_mag;
    logic signed [PID_W+1:0] sdiff, step_s;
    logic signed [PID_W-1:0] slew_next;
    assign cap_s  = $signed({3'b0, r_cap});
    assign drv_s  = (PID_W+1)'(r_drv);
    assign slew_s = (PID_W+1)'(r_slewed);
    always_comb begin
        if (drv_s > cap_s) begin
            target = cap_s;
        end else if (drv_s < -cap_s) begin
            target = -cap_s;
        end else begin
            target = drv_s;
        end
    end
    assign tgt_mag = target[PID_W] ? (PID_W+1)'(-target) : (PID_W+1)'(target);
    assign slw_mag = slew_s[PID_W] ? (PID_W+1)'(-slew_s) : (PID_W+1)'(slew_s);
    assign step_s  = (tgt_mag > slw_mag) ? $signed({4'b0, r_accel})
                                         : $signed({4'b0, r_decel});
    assign sdiff   = (PID_W+2)'(target) - (PID_W+2)'(slew_s);
    always_comb begin
        if (sdiff > step_s) begin
            slew_next = PID_W'((PID_W+2)'(slew_s) + step_s);
        end else if (sdiff < -step_s) begin
            slew_next = PID_W'((PID_W+2)'(slew_s) - step_s);
        end else begin
            slew_next = PID_W'(target);
        end
    end

    // heading clamp
    logic signed [PID_W:0]   hlim_s, hdg_s;
    logic signed [PID_W-1:0] head_next;
    assign hlim_s = $signed({3'b0, r_head_lim});
    assign hdg_s  = (PID_W+1)'(r_hdg);
    always_comb begin
        if (hdg_s > hlim_s) begin
            head_next = PID_W'(hlim_s);
        end else if (hdg_s < -hlim_s) begin
            head_next = PID_W'(-hlim_s);
        end else begin
            head_next = r_hdg;
        end
    end

    // settled and still test
    logic signed [ERR_W:0] edelta;
    logic [ERR_W:0]        edelta_mag;
    logic                  still;
    logic [7:0]            count_next;
    assign edelta     = (ERR_W+1)'(r_err) - (ERR_W+1)'(r_prev_err);
    assign edelta_mag = edelta[ERR_W] ? (ERR_W+1)'(-edelta) : (ERR_W+1)'(edelta);
    assign still      = !r_first && (err_mag < {1'b0, r_band})
                        && (edelta_mag < {2'b0, r_thresh});
    assign count_next = !still ? 8'd0 : (r_count == 8'hFF) ? r_count : r_count + 8'd1;

    // mix
    logic                    fin_now;
    logic signed [OUT_W-1:0] left_sum, right_sum;
    assign fin_now   = r_count >= FinishCount;
    assign left_sum  = OUT_W'(r_slewed + r_head_v);
    assign right_sum = OUT_W'(r_slewed - r_head_v);

    // ---------------- sequencer ----------------

    assign uw = ucode(r_step);

    always_comb begin
        case (uw.cond)
            COND_NEXT:     jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NOT_ZONE: jump = !in_zone;
            COND_DIV_BUSY: jump = r_cnt != CNT_W'(DIV_BITS - 1);
            COND_OUT_BUSY: jump = out_busy;
            default:       jump = 1'b0;
        endcase
    end

    assign n_step   = jump ? uw.target : r_step + STEP_W'(1);
    assign seq_done = r_busy && (uw.op == OP_MIX) && !out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_MUL;
        end else if (in_acc) begin
            r_busy <= 1'b1;
            r_step <= STEP_MUL;
        end else if (seq_done) begin
            r_busy <= 1'b0;
            r_step <= STEP_MUL;
        end else if (r_busy) begin
            r_step <= n_step;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_max  <= VOLT_W'(12000);
            r_head_lim <= VOLT_W'(6000);
            r_zone     <= '0;
            r_end      <= '0;
            r_accel    <= VOLT_W'(16000);
            r_decel    <= VOLT_W'(16000);
            r_band     <= DIST_W'(256);
            r_thresh   <= DIST_W'(13);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_DRIVE_CAP_MAX:    r_cap_max  <= i_cfg_data[VOLT_W-1:0];
                REG_HEADING_LIMIT:    r_head_lim <= i_cfg_data[VOLT_W-1:0];
                REG_SLOW_ZONE:        r_zone     <= i_cfg_data[DIST_W-1:0];
                REG_SLOW_END_VOLTAGE: r_end      <= i_cfg_data[VOLT_W-1:0];
                REG_SLEW_ACCEL:       r_accel    <= i_cfg_data[VOLT_W-1:0];
                REG_SLEW_DECEL:       r_decel    <= i_cfg_data[VOLT_W-1:0];
                REG_SETTLE_BAND:      r_band     <= i_cfg_data[DIST_W-1:0];
                REG_STILL_THRESHOLD:  r_thresh   <= i_cfg_data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // item capture, payload only
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_drv <= i_drive_pid_output;
            r_hdg <= i_heading_pid_output;
            r_err <= i_drive_error;
        end
    end

    // tick-to-tick state; a new move clears slew and settle count and sets the first-tick flag as the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slewed   <= '0;
            r_prev_err <= '0;
            r_first    <= 1'b1;
            r_count    <= '0;
        end else if (in_acc && i_new_move) begin
            r_slewed <= '0;
            r_first  <= 1'b1;
            r_count  <= '0;
        end else if (r_busy && uw.op == OP_SLEW) begin
            r_slewed   <= slew_next;
            r_prev_err <= r_err;
            r_first    <= 1'b0;
            r_count    <= count_next;
        end
    end

    // datapath working registers
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            case (uw.op)
                OP_MUL: begin
                    r_rem <= prod[VOLT_W+DIST_W-1:DIV_BITS];
                    r_quo <= prod[DIV_BITS-1:0];
                    r_neg <= span[VOLT_W];
                    r_cnt <= '0;
                end
                OP_DIV: begin
                    r_rem <= div_ge ? div_trial[DIST_W-1:0] : div_shift[DIST_W-1:0];
                    r_quo <= {r_quo[DIV_BITS-2:0], div_ge};
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                OP_TAPER: r_cap <= taper_cap;
                OP_BASE:  r_cap <= r_cap_max;
                OP_SLEW:  r_head_v <= head_next;
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_left  <= fin_now ? '0 : left_sum;
            r_right <= fin_now ? '0 : right_sum;
            r_fin   <= fin_now;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_left_voltage  = r_left;
    assign o_right_voltage = r_right;
    assign o_finished      = r_fin;

    // ---------------- assertions ----------------

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_busy && r_step == STEP_MUL)
        else $error("item accepted but program did not start");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= STEP_MIX)
        else $error("step counter left the program");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && uw.op == OP_DIV) |-> r_cnt < CNT_W'(DIV_BITS))
        else $error("divider ran past its quotient width");

    a_fin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_finished) |-> (o_left_voltage == '0 && o_right_voltage == '0))
        else $error("finished item carries nonzero voltage");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_done |-> !out_busy)
        else $error("result written over a waiting item");

endmodule
